@@ design/itr_pkg.sv @@
// itr_pkg: shared constants, register indexes and the pipeline control struct
// for the impedance tensor rotation core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package itr_pkg;

    // Default datapath sizing
    localparam int DATA_WIDTH_DEF     = 32;
    localparam int COEF_FRAC_BITS_DEF = 14;

    // Tensor layout: four complex elements, real and imaginary interleaved
    localparam int TENSOR_ELEMS = 8;

    // Angle registers (signed Q2.14)
    localparam int ANGLE_WIDTH = 16;
    localparam logic signed [ANGLE_WIDTH-1:0] COS_RESET = 16'sd16384;
    localparam logic signed [ANGLE_WIDTH-1:0] SIN_RESET = 16'sd0;

    // Configuration register indexes
    localparam int CFG_IDX_WIDTH = 2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_COS_ANGLE = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SIN_ANGLE = 2'd1;

    // Per-stage load enables of the datapath pipeline
    typedef struct packed {
        logic en_a;    // pre-add stage
        logic en_b;    // product stage
        logic en_c;    // sum, round and clip stage
        logic en_out;  // output register
    } itr_ctl_t;

endpackage

`default_nettype wire

@@ design/itr_coef.sv @@
// itr_coef: angle registers and the derived rotation coefficients
// cos^2, sin^2 and sin*cos. Depends on itr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itr_coef
    import itr_pkg::*;
#(
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    localparam int CW = 2 * ANGLE_WIDTH - COEF_FRAC_BITS
)(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [CFG_IDX_WIDTH-1:0]        cfg_index,
    input  wire logic [ANGLE_WIDTH-1:0]          cfg_data,
    output logic signed [CW-1:0]                 ca2,
    output logic signed [CW-1:0]                 sa2,
    output logic signed [CW-1:0]                 casa
);

    localparam int PW = 2 * ANGLE_WIDTH + 1;
    localparam logic signed [PW-1:0] RND = PW'(1) << (COEF_FRAC_BITS - 1);

    // Round a product to nearest (ties upward) at elaboration time
    function automatic longint round_prod(input longint a, input longint b);
        longint p;
        p = a * b + (longint'(1) <<< (COEF_FRAC_BITS - 1));
        return p >>> COEF_FRAC_BITS;
    endfunction

    localparam logic signed [CW-1:0] CA2_RST  =
        CW'(round_prod(longint'(COS_RESET), longint'(COS_RESET)));
    localparam logic signed [CW-1:0] SA2_RST  =
        CW'(round_prod(longint'(SIN_RESET), longint'(SIN_RESET)));
    localparam logic signed [CW-1:0] CASA_RST =
        CW'(round_prod(longint'(SIN_RESET), longint'(COS_RESET)));

    logic signed [ANGLE_WIDTH-1:0] cos_reg, cos_next;
    logic signed [ANGLE_WIDTH-1:0] sin_reg, sin_next;
    logic signed [CW-1:0]          ca2_reg, ca2_next;
    logic signed [CW-1:0]          sa2_reg, sa2_next;
    logic signed [CW-1:0]          casa_reg, casa_next;
    logic signed [PW-1:0]          pcc, pss, psc;

    // Decode register writes; other indexes are dropped
    always_comb
    begin
        cos_next = cos_reg;
        sin_next = sin_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_COS_ANGLE: cos_next = cfg_data;
                CFG_SIN_ANGLE: sin_next = cfg_data;
                default:       ;
            endcase
        end
    end

    // Form the coefficients from the held angle registers
    always_comb
    begin
        pcc       = PW'(cos_reg) * PW'(cos_reg) + RND;
        pss       = PW'(sin_reg) * PW'(sin_reg) + RND;
        psc       = PW'(sin_reg) * PW'(cos_reg) + RND;
        ca2_next  = CW'(pcc >>> COEF_FRAC_BITS);
        sa2_next  = CW'(pss >>> COEF_FRAC_BITS);
        casa_next = CW'(psc >>> COEF_FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg  <= COS_RESET;
            sin_reg  <= SIN_RESET;
            ca2_reg  <= CA2_RST;
            sa2_reg  <= SA2_RST;
            casa_reg <= CASA_RST;
        end
        else
        begin
            cos_reg  <= cos_next;
            sin_reg  <= sin_next;
            ca2_reg  <= ca2_next;
            sa2_reg  <= sa2_next;
            casa_reg <= casa_next;
        end
    end

    assign ca2  = ca2_reg;
    assign sa2  = sa2_reg;
    assign casa = casa_reg;

endmodule

`default_nettype wire

@@ design/itr_lane.sv @@
// itr_lane: one rotation lane (real or imaginary parts) with pre-add,
// product, and sum/round/clip stages. Depends on itr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itr_lane
    import itr_pkg::*;
#(
    parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
    localparam int CW = 2 * ANGLE_WIDTH - COEF_FRAC_BITS
)(
    input  wire logic                          clk,
    input  wire itr_ctl_t                      ctl,
    input  wire logic signed [DATA_WIDTH-1:0]  zxx,
    input  wire logic signed [DATA_WIDTH-1:0]  zxy,
    input  wire logic signed [DATA_WIDTH-1:0]  zyx,
    input  wire logic signed [DATA_WIDTH-1:0]  zyy,
    input  wire logic signed [CW-1:0]          ca2,
    input  wire logic signed [CW-1:0]          sa2,
    input  wire logic signed [CW-1:0]          casa,
    output logic [4*DATA_WIDTH-1:0]            res,   // xx, xy, yx, yy from bit 0 up
    output logic [3:0]                         sat    // xx, xy, yx, yy from bit 0 up
);

    localparam int AW = DATA_WIDTH + 1;
    localparam int PW = AW + CW;
    localparam int SW = PW + 2;
    localparam logic signed [SW-1:0] RND  = SW'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [SW-1:0] MAXV =
        {{(SW - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = ~MAXV;

    // Stage A: elements plus the off-diagonal sum and diagonal difference
    logic signed [DATA_WIDTH-1:0] zxx_a_reg, zxy_a_reg, zyx_a_reg, zyy_a_reg;
    logic signed [AW-1:0]         offd_a_reg, offd_a_next;
    logic signed [AW-1:0]         diag_a_reg, diag_a_next;

    // Stage B: products
    logic signed [PW-1:0] xxc_b_reg, xxs_b_reg, xyc_b_reg, xys_b_reg;
    logic signed [PW-1:0] yxc_b_reg, yxs_b_reg, yyc_b_reg, yys_b_reg;
    logic signed [PW-1:0] offd_b_reg, diag_b_reg;

    // Stage C: rounded and clipped results
    logic [4*DATA_WIDTH-1:0] res_c_reg, res_c_next;
    logic [3:0]              sat_c_reg, sat_c_next;
    logic signed [SW-1:0]    sums [4];
    logic signed [SW-1:0]    shv;

    always_comb
    begin
        offd_a_next = AW'(zxy) + AW'(zyx);
        diag_a_next = AW'(zxx) - AW'(zyy);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_a)
        begin
            zxx_a_reg  <= zxx;
            zxy_a_reg  <= zxy;
            zyx_a_reg  <= zyx;
            zyy_a_reg  <= zyy;
            offd_a_reg <= offd_a_next;
            diag_a_reg <= diag_a_next;
        end
    end

    // Multiply each term by its coefficient
    always_ff @(posedge clk)
    begin
        if (ctl.en_b)
        begin
            xxc_b_reg  <= PW'(zxx_a_reg) * PW'(ca2);
            xxs_b_reg  <= PW'(zxx_a_reg) * PW'(sa2);
            xyc_b_reg  <= PW'(zxy_a_reg) * PW'(ca2);
            xys_b_reg  <= PW'(zxy_a_reg) * PW'(sa2);
            yxc_b_reg  <= PW'(zyx_a_reg) * PW'(ca2);
            yxs_b_reg  <= PW'(zyx_a_reg) * PW'(sa2);
            yyc_b_reg  <= PW'(zyy_a_reg) * PW'(ca2);
            yys_b_reg  <= PW'(zyy_a_reg) * PW'(sa2);
            offd_b_reg <= PW'(offd_a_reg) * PW'(casa);
            diag_b_reg <= PW'(diag_a_reg) * PW'(casa);
        end
    end

    // Sum the products, round to nearest, and clip to the output range
    always_comb
    begin
        sums[0] = SW'(xxc_b_reg) - SW'(offd_b_reg) + SW'(yys_b_reg);
        sums[1] = SW'(xyc_b_reg) + SW'(diag_b_reg) - SW'(yxs_b_reg);
        sums[2] = SW'(yxc_b_reg) + SW'(diag_b_reg) - SW'(xys_b_reg);
        sums[3] = SW'(yyc_b_reg) + SW'(offd_b_reg) + SW'(xxs_b_reg);
        res_c_next = '0;
        sat_c_next = '0;
        shv        = '0;
        for (int i = 0; i < 4; i++)
        begin
            shv = (sums[i] + RND) >>> COEF_FRAC_BITS;
            if (shv > MAXV)
            begin
                res_c_next[i*DATA_WIDTH +: DATA_WIDTH] = MAXV[DATA_WIDTH-1:0];
                sat_c_next[i] = 1'b1;
            end
            else if (shv < MINV)
            begin
                res_c_next[i*DATA_WIDTH +: DATA_WIDTH] = MINV[DATA_WIDTH-1:0];
                sat_c_next[i] = 1'b1;
            end
            else
            begin
                res_c_next[i*DATA_WIDTH +: DATA_WIDTH] = shv[DATA_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_c)
        begin
            res_c_reg <= res_c_next;
            sat_c_reg <= sat_c_next;
        end
    end

    assign res = res_c_reg;
    assign sat = sat_c_reg;

endmodule

`default_nettype wire

@@ design/itr_merge.sv @@
// itr_merge: output register that interleaves the real and imaginary lane
// results and combines their saturation flags. Depends on itr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module itr_merge
    import itr_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)(
    input  wire logic                                clk,
    input  wire itr_ctl_t                            ctl,
    input  wire logic [4*DATA_WIDTH-1:0]             res_re,
    input  wire logic [4*DATA_WIDTH-1:0]             res_im,
    input  wire logic [3:0]                          sat_re,
    input  wire logic [3:0]                          sat_im,
    output logic [TENSOR_ELEMS*DATA_WIDTH-1:0]       tdata,
    output logic                                     saturated
);

    logic [TENSOR_ELEMS*DATA_WIDTH-1:0] tdata_reg, tdata_next;
    logic                               sat_reg, sat_next;

    // Interleave: element i real at slot 2i, imaginary at slot 2i+1
    always_comb
    begin
        tdata_next = '0;
        for (int i = 0; i < 4; i++)
        begin
            tdata_next[(2*i)*DATA_WIDTH +: DATA_WIDTH]   = res_re[i*DATA_WIDTH +: DATA_WIDTH];
            tdata_next[(2*i+1)*DATA_WIDTH +: DATA_WIDTH] = res_im[i*DATA_WIDTH +: DATA_WIDTH];
        end
        sat_next = (|sat_re) | (|sat_im);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en_out)
        begin
            tdata_reg <= tdata_next;
            sat_reg   <= sat_next;
        end
    end

    assign tdata     = tdata_reg;
    assign saturated = sat_reg;

endmodule

`default_nettype wire

@@ design/impedance_tensor_rotation_core.sv @@
// impedance_tensor_rotation_core: top level, rotates a complex 2x2 tensor as
// R Z R^T. Depends on itr_pkg, itr_coef, itr_lane and itr_merge.
//
//   channel   direction  signals                            contents
//   s_axis    in         tvalid tready tdata                input tensor
//   m_axis    out        tvalid tready tdata tuser          rotated tensor, saturation flag
//   cfg       in         cfg_we cfg_index cfg_data          angle registers, no read-back
//
// Throughput is one tensor per cycle while the output is not stalled; a tensor passes the
// pre-add, product and sum/round/clip stages of the two lanes and the output register in
// itr_merge to m_axis_tvalid. Coefficients are registered from the written angle registers.
// Reset clears the valid bits of all stages and restores cos = 1.0, sin = 0.
// Each stage holds only while it is full and the stage after it holds, so input
// transactions are taken while bubbles remain ahead of a stalled output.
`timescale 1ns / 1ps
`default_nettype none

module impedance_tensor_rotation_core
    import itr_pkg::*;
#(
    parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
)(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // in_xx_re, in_xx_im, in_xy_re, in_xy_im, in_yx_re, in_yx_im, in_yy_re, in_yy_im
    input  wire logic [TENSOR_ELEMS*DATA_WIDTH-1:0]    s_axis_tdata,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // out_xx_re, out_xx_im, out_xy_re, out_xy_im, out_yx_re, out_yx_im, out_yy_re, out_yy_im
    output logic [TENSOR_ELEMS*DATA_WIDTH-1:0]         m_axis_tdata,
    // saturated
    output logic                                       m_axis_tuser,
    input  wire logic                                  cfg_we,
    input  wire logic [CFG_IDX_WIDTH-1:0]              cfg_index,
    input  wire logic [ANGLE_WIDTH-1:0]                cfg_data
);

    localparam int CW = 2 * ANGLE_WIDTH - COEF_FRAC_BITS;

    logic signed [CW-1:0]    ca2, sa2, casa;
    logic [4*DATA_WIDTH-1:0] res_re, res_im;
    logic [3:0]              sat_re, sat_im;
    itr_ctl_t                ctl;

    logic v_a_reg, v_a_next;
    logic v_b_reg, v_b_next;
    logic v_c_reg, v_c_next;
    logic v_out_reg, v_out_next;
    logic rdy_a, rdy_b, rdy_c, rdy_out;

    // Advance each stage when it is empty or the next one moves
    always_comb
    begin
        rdy_out    = !v_out_reg || m_axis_tready;
        rdy_c      = !v_c_reg || rdy_out;
        rdy_b      = !v_b_reg || rdy_c;
        rdy_a      = !v_a_reg || rdy_b;
        ctl.en_a   = rdy_a;
        ctl.en_b   = rdy_b;
        ctl.en_c   = rdy_c;
        ctl.en_out = rdy_out;
        v_a_next   = rdy_a   ? s_axis_tvalid : v_a_reg;
        v_b_next   = rdy_b   ? v_a_reg       : v_b_reg;
        v_c_next   = rdy_c   ? v_b_reg       : v_c_reg;
        v_out_next = rdy_out ? v_c_reg       : v_out_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg   <= 1'b0;
            v_b_reg   <= 1'b0;
            v_c_reg   <= 1'b0;
            v_out_reg <= 1'b0;
        end
        else
        begin
            v_a_reg   <= v_a_next;
            v_b_reg   <= v_b_next;
            v_c_reg   <= v_c_next;
            v_out_reg <= v_out_next;
        end
    end

    assign s_axis_tready = rdy_a;
    assign m_axis_tvalid = v_out_reg;

    // Angle registers and coefficients
    itr_coef #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ca2       (ca2),
        .sa2       (sa2),
        .casa      (casa)
    );

    // Real-part lane
    itr_lane #(
        .DATA_WIDTH     (DATA_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_re (
        .clk  (clk),
        .ctl  (ctl),
        .zxx  (s_axis_tdata[0*DATA_WIDTH +: DATA_WIDTH]),
        .zxy  (s_axis_tdata[2*DATA_WIDTH +: DATA_WIDTH]),
        .zyx  (s_axis_tdata[4*DATA_WIDTH +: DATA_WIDTH]),
        .zyy  (s_axis_tdata[6*DATA_WIDTH +: DATA_WIDTH]),
        .ca2  (ca2),
        .sa2  (sa2),
        .casa (casa),
        .res  (res_re),
        .sat  (sat_re)
    );

    // Imaginary-part lane
    itr_lane #(
        .DATA_WIDTH     (DATA_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane_im (
        .clk  (clk),
        .ctl  (ctl),
        .zxx  (s_axis_tdata[1*DATA_WIDTH +: DATA_WIDTH]),
        .zxy  (s_axis_tdata[3*DATA_WIDTH +: DATA_WIDTH]),
        .zyx  (s_axis_tdata[5*DATA_WIDTH +: DATA_WIDTH]),
        .zyy  (s_axis_tdata[7*DATA_WIDTH +: DATA_WIDTH]),
        .ca2  (ca2),
        .sa2  (sa2),
        .casa (casa),
        .res  (res_im),
        .sat  (sat_im)
    );

    // Interleave lanes into the output register
    itr_merge #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_merge (
        .clk       (clk),
        .ctl       (ctl),
        .res_re    (res_re),
        .res_im    (res_im),
        .sat_re    (sat_re),
        .sat_im    (sat_im),
        .tdata     (m_axis_tdata),
        .saturated (m_axis_tuser)
    );

endmodule

`default_nettype wire

@@ design/itr_checker.sv @@
// itr_checker: port-level assertions for impedance_tensor_rotation_core and
// the bind that attaches them. Depends on the top level's ports only.
`timescale 1ns / 1ps
`default_nettype none

module itr_checker #(
    parameter int TDATA_WIDTH = 256
)(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [TDATA_WIDTH-1:0] m_axis_tdata,
    input wire logic                   m_axis_tuser
);

    // Hold a result transaction until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("m_axis_tvalid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("m_axis payload changed while stalled");

    // Input stalls only when the output is backed up
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("s_axis_tready low without output backpressure");

    // An accepted tensor reaches the output if m_axis_tready stays high while it passes the stages
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
            ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("result missing after pipeline latency");

endmodule

bind impedance_tensor_rotation_core itr_checker #(
    .TDATA_WIDTH ($bits(m_axis_tdata))
) u_itr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ tb/itr_rotation_checker.sv @@
// itr_rotation_checker: watches the stream and config ports of the tensor rotation core,
// predicts each rotated tensor and compares it with what the core delivers.
// Depends on itr_pkg for the tensor layout, angle width and register indexes.
`timescale 1ns / 1ps

module itr_rotation_checker
    import itr_pkg::*;
#(
    parameter int DW   = DATA_WIDTH_DEF,
    parameter int FRAC = COEF_FRAC_BITS_DEF
)(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tready,
    input  wire logic [TENSOR_ELEMS*DW-1:0]    s_axis_tdata,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [TENSOR_ELEMS*DW-1:0]    m_axis_tdata,
    input  wire logic                          m_axis_tuser,
    input  wire logic                          cfg_we,
    input  wire logic [CFG_IDX_WIDTH-1:0]      cfg_index,
    input  wire logic [ANGLE_WIDTH-1:0]        cfg_data,
    output int                                 fault_count,
    output int                                 outstanding
);

    typedef struct packed {
        logic                       sat;
        logic [TENSOR_ELEMS*DW-1:0] elems;
    } rotated_t;

    localparam longint ELEM_MAX = (longint'(1) <<< (DW - 1)) - 1;
    localparam longint ELEM_MIN = -ELEM_MAX - 1;

    logic signed [ANGLE_WIDTH-1:0] cos_angle_q = COS_RESET;
    logic signed [ANGLE_WIDTH-1:0] sin_angle_q = SIN_RESET;
    rotated_t                      rotated_q[$];
    string                         elem_name[TENSOR_ELEMS] = '{
        "xx_re", "xx_im", "xy_re", "xy_im", "yx_re", "yx_im", "yy_re", "yy_im"};

    initial
    begin
        fault_count = 0;
        outstanding = 0;
    end

    // Print a mismatch and count it
    task automatic report_fault(input string msg);
        $display("%0t checker: %s", $time, msg);
        fault_count++;
    endtask

    // Add half an LSB, then shift arithmetically: ties go toward plus infinity
    function automatic longint round_drop(input longint x);
        return (x + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    // Sign-extend one tensor element
    function automatic longint elem_at(input logic [TENSOR_ELEMS*DW-1:0] t, input int idx);
        logic signed [DW-1:0] e;
        e = t[idx*DW +: DW];
        return longint'(e);
    endfunction

    // Rotate one tensor as R Z R^T with the angle registers given
    function automatic rotated_t rotate_tensor(input logic [TENSOR_ELEMS*DW-1:0] t,
                                               input logic signed [ANGLE_WIDTH-1:0] cos_a,
                                               input logic signed [ANGLE_WIDTH-1:0] sin_a);
        longint   c, s, ca2, sa2, casa;
        longint   zxx, zxy, zyx, zyy, offd, diag, v;
        longint   sums[4];
        rotated_t r;
        int       p, k;
        c    = longint'(cos_a);
        s    = longint'(sin_a);
        ca2  = round_drop(c * c);
        sa2  = round_drop(s * s);
        casa = round_drop(s * c);
        r    = '0;
        // Real parts on the first pass, imaginary parts on the second
        for (p = 0; p < 2; p++)
        begin
            zxx  = elem_at(t, 0 + p);
            zxy  = elem_at(t, 2 + p);
            zyx  = elem_at(t, 4 + p);
            zyy  = elem_at(t, 6 + p);
            offd = zxy + zyx;
            diag = zxx - zyy;
            sums[0] = zxx * ca2 - offd * casa + zyy * sa2;
            sums[1] = zxy * ca2 + diag * casa - zyx * sa2;
            sums[2] = zyx * ca2 + diag * casa - zxy * sa2;
            sums[3] = zyy * ca2 + offd * casa + zxx * sa2;
            for (k = 0; k < 4; k++)
            begin
                v = round_drop(sums[k]);
                if (v > ELEM_MAX)
                begin
                    v     = ELEM_MAX;
                    r.sat = 1'b1;
                end
                else if (v < ELEM_MIN)
                begin
                    v     = ELEM_MIN;
                    r.sat = 1'b1;
                end
                r.elems[(2*k+p)*DW +: DW] = v[DW-1:0];
            end
        end
        return r;
    endfunction

    // Compare delivered tensors, queue predictions, track the angle registers
    always @(posedge clk or negedge rst_n)
    begin : monitor
        rotated_t             got;
        rotated_t             want;
        logic signed [DW-1:0] got_e;
        logic signed [DW-1:0] want_e;
        int                   i;
        if (!rst_n)
        begin
            rotated_q.delete();
            cos_angle_q = COS_RESET;
            sin_angle_q = SIN_RESET;
            outstanding <= 0;
        end
        else
        begin
            // Check the output transaction against the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tuser, m_axis_tdata};
                if (rotated_q.size() == 0)
                    report_fault("output transaction with no tensor pending");
                else
                begin
                    want = rotated_q.pop_front();
                    for (i = 0; i < TENSOR_ELEMS; i++)
                    begin
                        got_e  = got.elems[i*DW +: DW];
                        want_e = want.elems[i*DW +: DW];
                        if (got_e !== want_e)
                            report_fault($sformatf("%s got %0d expected %0d",
                                                   elem_name[i], got_e, want_e));
                    end
                    if (got.sat !== want.sat)
                        report_fault($sformatf("saturated got %b expected %b",
                                               got.sat, want.sat));
                end
            end
            // Predict the input transaction with the current angle
            if (s_axis_tvalid && s_axis_tready)
                rotated_q.push_back(rotate_tensor(s_axis_tdata, cos_angle_q, sin_angle_q));
            // Follow register writes; other indexes are dropped by the core
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_COS_ANGLE: cos_angle_q = cfg_data;
                    CFG_SIN_ANGLE: sin_angle_q = cfg_data;
                    default: ;
                endcase
            end
            outstanding <= rotated_q.size();
        end
    end

endmodule

@@ tb/impedance_tensor_rotation_core_tb.sv @@
// impedance_tensor_rotation_core_tb: drives tensors and angle settings into the rotation
// core with bursty input and a stalling output, and reports the verdict.
// Depends on itr_pkg, impedance_tensor_rotation_core and itr_rotation_checker.
`timescale 1ns / 1ps

module impedance_tensor_rotation_core_tb;
    import itr_pkg::*;

    localparam int DW            = DATA_WIDTH_DEF;
    localparam int TW            = TENSOR_ELEMS * DW;
    localparam int PIPE_LATENCY  = 4;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int RANDOM_PHASES = 8;

    // Indexes that the core has no register for
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_HI = 2'd3;

    localparam logic signed [DW-1:0] ZMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] ZMIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_MAX = {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
    localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_MIN = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
    localparam logic signed [ANGLE_WIDTH-1:0] Q_ONE     = 16'sd16384;
    localparam logic signed [ANGLE_WIDTH-1:0] Q_SQRT_HALF = 16'sd11585;

    logic                     clk           = 1'b0;
    logic                     rst_n         = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [TW-1:0]            s_axis_tdata  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [TW-1:0]            m_axis_tdata;
    logic                     m_axis_tuser;
    logic                     cfg_we        = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] cfg_index     = '0;
    logic [ANGLE_WIDTH-1:0]   cfg_data      = '0;
    int                       fault_count;
    int                       outstanding;
    int                       rx_run        = 0;

    impedance_tensor_rotation_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    itr_rotation_checker #(
        .DW   (DW),
        .FRAC (COEF_FRAC_BITS_DEF)
    ) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fault_count   (fault_count),
        .outstanding   (outstanding)
    );

    // 4 ns clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // Timeout
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // Output stall pattern: long ready runs, stall runs and per-cycle random ready
    always @(posedge clk)
    begin
        if (rx_run > 0)
            rx_run--;
        else
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    m_axis_tready <= 1'b1;
                    rx_run = $urandom_range(10, 60);
                end
                1:
                begin
                    m_axis_tready <= 1'b0;
                    rx_run = $urandom_range(0, 10);
                end
                default:
                begin
                    m_axis_tready <= ($urandom_range(0, 1) == 1);
                    rx_run = 0;
                end
            endcase
        end
    end

    // Pack eight elements, xx_re in the lowest bits
    function automatic logic [TW-1:0] pack_tensor(
        input logic signed [DW-1:0] xx_re, input logic signed [DW-1:0] xx_im,
        input logic signed [DW-1:0] xy_re, input logic signed [DW-1:0] xy_im,
        input logic signed [DW-1:0] yx_re, input logic signed [DW-1:0] yx_im,
        input logic signed [DW-1:0] yy_re, input logic signed [DW-1:0] yy_im);
        return {yy_im, yy_re, yx_im, yx_re, xy_im, xy_re, xx_im, xx_re};
    endfunction

    // Random tensor: mostly full-range, some built from extremes or small values
    function automatic logic [TW-1:0] random_tensor();
        logic [TW-1:0] t;
        int            shape;
        int            kind;
        int            k;
        shape = $urandom_range(0, 7);
        for (k = 0; k < TENSOR_ELEMS; k++)
        begin
            if (shape < 4)
                kind = 0;
            else if (shape < 6)
                kind = shape - 3;
            else
                kind = $urandom_range(0, 2);
            case (kind)
                0: t[k*DW +: DW] = $urandom();
                1:
                begin
                    case ($urandom_range(0, 4))
                        0: t[k*DW +: DW] = ZMAX;
                        1: t[k*DW +: DW] = ZMIN;
                        2: t[k*DW +: DW] = '0;
                        3: t[k*DW +: DW] = '1;
                        default: t[k*DW +: DW] = 1;
                    endcase
                end
                default: t[k*DW +: DW] = $urandom_range(0, 65535) - 32768;
            endcase
        end
        return t;
    endfunction

    // Random angle register value, mostly within [-1.0, 1.0]
    function automatic logic [ANGLE_WIDTH-1:0] random_angle();
        case ($urandom_range(0, 3))
            0: return ANGLE_WIDTH'($urandom());
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return ANGLE_MAX;
                    1: return ANGLE_MIN;
                    2: return Q_ONE;
                    3: return -Q_ONE;
                    default: return '0;
                endcase
            end
            default: return ANGLE_WIDTH'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    // Present one tensor and hold it until the core takes it
    task automatic send_tensor(input logic [TW-1:0] t);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Drop valid for the gap between bursts
    task automatic end_burst(input int gap);
        s_axis_tvalid <= 1'b0;
        repeat (gap + 1) @(posedge clk);
    endtask

    // Hold off input until every pending tensor has come out
    task automatic drain_pipeline();
        if (s_axis_tvalid)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        while (outstanding != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    // Write both angles plus an unused index, then let the coefficients settle
    task automatic set_angles(input logic [ANGLE_WIDTH-1:0] cos_a,
                              input logic [ANGLE_WIDTH-1:0] sin_a);
        cfg_we    <= 1'b1;
        cfg_index <= ($urandom_range(0, 1) == 1) ? CFG_SPARE_HI : CFG_SPARE_LO;
        cfg_data  <= ANGLE_WIDTH'($urandom());
        @(posedge clk);
        cfg_index <= CFG_COS_ANGLE;
        cfg_data  <= cos_a;
        @(posedge clk);
        cfg_index <= CFG_SIN_ANGLE;
        cfg_data  <= sin_a;
        @(posedge clk);
        cfg_we    <= 1'b0;
        repeat (3) @(posedge clk);
    endtask

    // Stimulus
    initial
    begin : stimulus
        logic signed [ANGLE_WIDTH-1:0] cos_a;
        logic signed [ANGLE_WIDTH-1:0] sin_a;
        int                            phase;
        int                            n;
        int                            burst_left;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset angle (identity): field extremes pass straight through
        send_tensor('0);
        send_tensor(pack_tensor(ZMAX, ZMAX, ZMAX, ZMAX, ZMAX, ZMAX, ZMAX, ZMAX));
        send_tensor(pack_tensor(ZMIN, ZMIN, ZMIN, ZMIN, ZMIN, ZMIN, ZMIN, ZMIN));
        send_tensor(pack_tensor(ZMAX, ZMIN, ZMIN, ZMAX, ZMAX, ZMIN, ZMIN, ZMAX));
        send_tensor(pack_tensor(1, -1, 2, -2, 3, -3, 4, -4));
        send_tensor(random_tensor());
        drain_pipeline();

        // Most negative angle registers: coefficients of 4.0, saturation and wide sums
        set_angles(ANGLE_MIN, ANGLE_MIN);
        send_tensor(pack_tensor(ZMAX, ZMAX, ZMAX, ZMAX, ZMAX, ZMAX, ZMAX, ZMAX));
        send_tensor('0);
        send_tensor(pack_tensor(ZMIN, ZMIN, ZMIN, ZMIN, ZMIN, ZMIN, ZMIN, ZMIN));
        send_tensor(pack_tensor(ZMAX, ZMIN, ZMAX, ZMAX, ZMAX, ZMIN, ZMIN, ZMAX));
        send_tensor(pack_tensor(1, 1, 1, 1, 1, 1, 1, 1));
        send_tensor(random_tensor());
        drain_pipeline();

        // Coefficients of one LSB: rounding ties on both signs
        set_angles(16'sd128, 16'sd128);
        send_tensor(pack_tensor(8192, 8191, 0, 0, 0, 0, 0, 0));
        send_tensor(pack_tensor(-8192, -8193, 0, 0, 0, 0, 0, 0));
        send_tensor(pack_tensor(0, 0, 8192, -8192, 24576, -24576, 0, 0));
        send_tensor(pack_tensor(0, 0, 0, 0, 0, 0, 8192, -8192));
        send_tensor(pack_tensor(4096, -4096, 4096, -4096, 0, 0, -8192, 8192));
        send_tensor(random_tensor());
        drain_pipeline();

        // Random tensors over a series of angle settings, extremes first
        burst_left = $urandom_range(1, 24);
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: begin cos_a = '0;          sin_a = Q_ONE;        end
                1: begin cos_a = -Q_ONE;      sin_a = '0;           end
                2: begin cos_a = '0;          sin_a = -Q_ONE;       end
                3: begin cos_a = Q_SQRT_HALF; sin_a = -Q_SQRT_HALF; end
                4: begin cos_a = ANGLE_MAX;   sin_a = ANGLE_MIN;    end
                default:
                begin
                    cos_a = random_angle();
                    sin_a = random_angle();
                end
            endcase
            set_angles(cos_a, sin_a);
            for (n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++)
            begin
                send_tensor(random_tensor());
                burst_left--;
                if (burst_left == 0)
                begin
                    end_burst(($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                          : $urandom_range(0, 6));
                    burst_left = $urandom_range(1, 24);
                end
                // Now and then let the core run dry before going on
                if ($urandom_range(0, 199) == 0)
                    drain_pipeline();
            end
            drain_pipeline();
        end

        // Verdict
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        if (fault_count == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
design/itr_pkg.sv
design/itr_coef.sv
design/itr_lane.sv
design/itr_merge.sv
design/impedance_tensor_rotation_core.sv
design/itr_checker.sv
tb/itr_rotation_checker.sv
tb/impedance_tensor_rotation_core_tb.sv
